[design/ascl_pkg.sv]
// Package: request/result types and codes for the surface descriptor cache.
package ascl_pkg;

	localparam logic [1:0] REQ_LOOKUP = 2'd0;
	localparam logic [1:0] REQ_INVAL  = 2'd1;
	localparam logic [1:0] REQ_FLUSH  = 2'd2;

	localparam logic [2:0] ST_HIT     = 3'd0;
	localparam logic [2:0] ST_FILL    = 3'd1;
	localparam logic [2:0] ST_EVICT   = 3'd2;
	localparam logic [2:0] ST_REJECT  = 3'd3;
	localparam logic [2:0] ST_INVAL   = 3'd4;
	localparam logic [2:0] ST_ABSENT  = 3'd5;
	localparam logic [2:0] ST_FLUSHED = 3'd6;

	localparam logic [15:0] MAX_DIM_RESET = 16'd2048;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] surface_key;
		logic [15:0] surface_width;
		logic [15:0] surface_height;
		logic [17:0] row_stride;
		logic        format_alpha;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [5:0]  slot_index;
		logic        rebuilt;
		logic [31:0] released_key;
	} res_t;

	// classified request handed from front to back
	typedef struct packed {
		req_t req;
		logic reject;
	} cmd_t;

endpackage

[design/ascl_ram.sv]
// Generic single-port-write, one-read RAM with registered read data.
module ascl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[design/ascl_front.sv]
// Front end: validates requests and queues them for the back end.
module ascl_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [15:0]           cfg_data,
	input  logic                  push,
	output logic                  full,
	input  ascl_pkg::req_t        req,
	output logic                  cmd_valid,
	input  logic                  cmd_take,
	output ascl_pkg::cmd_t        cmd
);

	logic [15:0]    max_dim_q;
	ascl_pkg::cmd_t buf_q [2];
	logic           wr_q, rd_q;
	logic [1:0]     cnt_q;
	logic           bad;
	logic           do_push;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_dim_q <= ascl_pkg::MAX_DIM_RESET;
		end else if (cfg_we) begin
			max_dim_q <= cfg_data;
		end
	end

	// lookup check; other request types are handled in the back end
	always_comb begin
		bad = (req.surface_key == '0) || (req.surface_width == '0)
			|| (req.surface_height == '0)
			|| (req.row_stride < {req.surface_width, 2'b00})
			|| (req.surface_width > max_dim_q) || (req.surface_height > max_dim_q);
	end

	assign full      = cnt_q[1];
	assign do_push   = push && !full;
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd       = buf_q[rd_q];

	// two-entry queue
	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wr_q] <= '{req: req, reject: bad};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= !wr_q;
			if (cmd_take) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, cmd_take};
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2) else $error("queue count out of range");
	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |-> cmd_valid) else $error("take from empty queue");
	a_full_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !cmd_take) |=> full) else $error("full dropped");
`endif

endmodule

[design/ascl_back.sv]
// Back end: scans the entries, updates the cache and queues the result.
module ascl_back #(
	parameter int ENTRIES    = 64,
	parameter int STAMP_BITS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_take,
	input  ascl_pkg::cmd_t cmd,
	output logic           empty,
	input  logic           pop,
	output ascl_pkg::res_t res
);

	localparam int IW = $clog2(ENTRIES);
	localparam int DW = 16 + 16 + 18 + 1;
	localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_CHECK = 3'd2;
	localparam logic [2:0] S_WRITE = 3'd3;
	localparam logic [2:0] S_OUT   = 3'd4;

	logic [2:0]            state_q;
	ascl_pkg::req_t        req_q;
	logic [IW-1:0]         idx_q;
	logic [IW-1:0]         idx_d1_q;
	logic                  rd_valid_q;
	logic [ENTRIES-1:0]    vld_q;
	logic                  found_q;
	logic [IW-1:0]         found_idx_q;
	logic                  free_q;
	logic [IW-1:0]         free_idx_q;
	logic [IW-1:0]         lru_idx_q;
	logic [STAMP_BITS-1:0] lru_stamp_q;
	logic [31:0]           lru_key_q;
	logic                  lru_any_q;
	logic [STAMP_BITS-1:0] clock_q;
	ascl_pkg::res_t        fin_q;
	ascl_pkg::res_t        out_q;
	logic                  out_full_q;

	logic                  st_we, dt_we;
	logic [IW-1:0]         st_addr, dt_addr;
	logic [STAMP_BITS-1:0] st_wdata, st_rdata;
	logic [DW-1:0]         dt_wdata, dt_rdata;
	logic [31:0]           key_rdata;
	logic [IW-1:0]         rd_addr;
	logic [STAMP_BITS-1:0] next_clock;
	logic                  match_rd;
	logic [DW-1:0]         req_desc;
	logic                  out_free;
	logic                  key_hit;
	logic [IW-1:0]         found_sel;
	logic [IW-1:0]         new_slot;
	logic [ENTRIES-1:0]    clr_mask;
	logic [ENTRIES-1:0]    set_mask;

	assign next_clock = clock_q + 1'b1;
	assign req_desc = {req_q.surface_width, req_q.surface_height, req_q.row_stride,
		req_q.format_alpha};
	assign out_free = !out_full_q || pop;
	assign empty = !out_full_q;
	assign res = out_q;
	assign cmd_take = (state_q == S_IDLE) && cmd_valid;

	// read address: scan index, then the found entry (or the last entry while it is checked)
	assign rd_addr = (state_q == S_SCAN) ? idx_q : (found_q ? found_idx_q : idx_d1_q);

	ascl_ram #(.WIDTH(STAMP_BITS), .DEPTH(ENTRIES)) u_stamp (
		.clk(clk), .we(st_we), .waddr(st_addr), .wdata(st_wdata),
		.raddr(rd_addr), .rdata(st_rdata)
	);

	ascl_ram #(.WIDTH(DW), .DEPTH(ENTRIES)) u_desc (
		.clk(clk), .we(dt_we), .waddr(dt_addr), .wdata(dt_wdata),
		.raddr(rd_addr), .rdata(dt_rdata)
	);

	ascl_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_key (
		.clk(clk), .we(dt_we), .waddr(dt_addr), .wdata(req_q.surface_key),
		.raddr(rd_addr), .rdata(key_rdata)
	);

	assign match_rd = (dt_rdata == req_desc);

	// key compare on the entry read in the cycle before
	assign key_hit = rd_valid_q && vld_q[idx_d1_q] && (key_rdata == req_q.surface_key)
		&& (req_q.surface_key != '0) && !found_q;
	assign found_sel = found_q ? found_idx_q : idx_d1_q;

	// target of a fill: a rebuild reuses the lowest free slot once its own entry is freed
	always_comb begin
		if (found_q) begin
			new_slot = (free_q && free_idx_q < found_idx_q) ? free_idx_q : found_idx_q;
		end else if (free_q) begin
			new_slot = free_idx_q;
		end else begin
			new_slot = lru_idx_q;
		end
	end

	assign clr_mask = found_q ? (ENTRIES'(1) << found_idx_q) : '0;
	assign set_mask = ENTRIES'(1) << new_slot;

	// write ports are used only in the write state
	always_comb begin
		st_we    = 1'b0;
		dt_we    = 1'b0;
		st_addr  = found_idx_q;
		dt_addr  = found_idx_q;
		st_wdata = next_clock;
		dt_wdata = req_desc;
		if (state_q == S_WRITE) begin
			st_we = 1'b1;
			if (!(found_q && match_rd)) begin
				dt_we   = 1'b1;
				st_addr = new_slot;
				dt_addr = new_slot;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			vld_q      <= '0;
			clock_q    <= '0;
			out_full_q <= 1'b0;
			rd_valid_q <= 1'b0;
			idx_q      <= '0;
			found_q    <= 1'b0;
			free_q     <= 1'b0;
			lru_any_q  <= 1'b0;
		end else begin
			if (pop) out_full_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						req_q      <= cmd.req;
						idx_q      <= '0;
						rd_valid_q <= 1'b0;
						found_q    <= 1'b0;
						free_q     <= 1'b0;
						lru_any_q  <= 1'b0;
						if (cmd.req.req_type == ascl_pkg::REQ_FLUSH) begin
							vld_q <= '0;
							fin_q <= '{ascl_pkg::ST_FLUSHED, 6'd0, 1'b0, 32'd0};
							state_q <= S_OUT;
						end else if (cmd.req.req_type == ascl_pkg::REQ_INVAL) begin
							state_q <= S_SCAN;
						end else if (cmd.req.req_type != ascl_pkg::REQ_LOOKUP
							|| cmd.reject) begin
							fin_q <= '{ascl_pkg::ST_REJECT, 6'd0, 1'b0, 32'd0};
							state_q <= S_OUT;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					// key and stamp compare on the index issued in the cycle before
					if (key_hit) begin
						found_q     <= 1'b1;
						found_idx_q <= idx_d1_q;
					end
					if (!vld_q[idx_q] && !free_q) begin
						free_q     <= 1'b1;
						free_idx_q <= idx_q;
					end
					if (rd_valid_q && (!lru_any_q || st_rdata < lru_stamp_q)) begin
						lru_any_q   <= 1'b1;
						lru_stamp_q <= st_rdata;
						lru_idx_q   <= idx_d1_q;
						lru_key_q   <= key_rdata;
					end
					idx_d1_q   <= idx_q;
					rd_valid_q <= 1'b1;
					if (idx_q == LAST) begin
						state_q <= S_CHECK;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_CHECK: begin
					// last key and stamp; descriptor of found entry read this cycle
					if (key_hit) begin
						found_q     <= 1'b1;
						found_idx_q <= idx_d1_q;
					end
					if (!lru_any_q || st_rdata < lru_stamp_q) begin
						lru_stamp_q <= st_rdata;
						lru_idx_q   <= idx_d1_q;
						lru_key_q   <= key_rdata;
					end
					lru_any_q <= 1'b1;
					if (req_q.req_type == ascl_pkg::REQ_INVAL) begin
						if (found_q || key_hit) begin
							vld_q[found_sel] <= 1'b0;
							fin_q <= '{ascl_pkg::ST_INVAL, 6'(found_sel), 1'b0,
								req_q.surface_key};
						end else begin
							fin_q <= '{ascl_pkg::ST_ABSENT, 6'd0, 1'b0, 32'd0};
						end
						state_q <= S_OUT;
					end else begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					clock_q <= next_clock;
					if (found_q && match_rd) begin
						fin_q <= '{ascl_pkg::ST_HIT, 6'(found_idx_q), 1'b0, 32'd0};
					end else begin
						vld_q <= (vld_q & ~clr_mask) | set_mask;
						if (found_q) begin
							fin_q <= '{ascl_pkg::ST_FILL, 6'(new_slot), 1'b1,
								req_q.surface_key};
						end else if (free_q) begin
							fin_q <= '{ascl_pkg::ST_FILL, 6'(new_slot), 1'b0, 32'd0};
						end else begin
							fin_q <= '{ascl_pkg::ST_EVICT, 6'(new_slot), 1'b0, lru_key_q};
						end
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					// hand over to the result register once it is free
					if (out_free) begin
						out_q      <= fin_q;
						out_full_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_pop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_full_q && !pop) |=> (out_full_q && $stable(out_q)))
		else $error("result changed while waiting");
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |=> state_q != S_IDLE) else $error("take without start");
	a_hit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRITE && found_q) |-> vld_q[found_idx_q])
		else $error("found entry not valid");
`endif

endmodule

[design/assoc_surface_cache_lru_core.sv]
// Top level: fully associative surface descriptor cache with LRU replacement.
// Each request takes one result. All requests pass the front queue first.
// Flush, rejected and unused requests go from idle straight to output; lookups
// scan every entry once through the key, stamp and descriptor RAM read port,
// then check and write, and invalidates scan and check without the write. A
// two-deep queue separates request acceptance from the scanning back end, and
// a result register holds the answer until it is popped while the back end
// finishes the next request. max_dimension resets to 2048.
module assoc_surface_cache_lru_core #(
	parameter int ENTRIES    = 64,
	parameter int STAMP_BITS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [15:0]    cfg_data,
	input  logic           push,
	output logic           full,
	input  ascl_pkg::req_t req,
	output logic           empty,
	input  logic           pop,
	output ascl_pkg::res_t res
);

	logic           cmd_valid;
	logic           cmd_take;
	ascl_pkg::cmd_t cmd;

	ascl_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.push(push), .full(full), .req(req),
		.cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
	);

	ascl_back #(.ENTRIES(ENTRIES), .STAMP_BITS(STAMP_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
		.cmd(cmd), .empty(empty), .pop(pop), .res(res)
	);

endmodule
